>>> hdl/pbts_pkg.sv
`default_nettype none

package pbts_pkg;

  localparam int NUM_TASKS = 8;
  localparam int TASK_W    = $clog2(NUM_TASKS);
  localparam int PRIO_W    = TASK_W + 1;
  localparam int IDX_W     = TASK_W + 1;
  localparam int DLY_W     = 16;
  localparam int MS_W      = 10;
  localparam int FUNC_W    = 3;

  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUSPEND = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESUME  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DELAY   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LOCK    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_UNLOCK  = 3'd5;

  localparam logic [MS_W-1:0]   MS_RESET  = 10'd1;
  localparam logic [PRIO_W-1:0] PRIO_NONE = PRIO_W'(NUM_TASKS);
  localparam logic [TASK_W-1:0] IDLE_TASK = TASK_W'(NUM_TASKS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_EXEC,
    S_DONE
  } state_t;

  // lowest set bit wins, none gives NUM_TASKS
  function automatic logic [PRIO_W-1:0] pick_prio(input logic [NUM_TASKS-1:0] map);
    logic [PRIO_W-1:0] res;
    res = PRIO_NONE;
    for (int i = NUM_TASKS - 1; i >= 0; i--) begin
      if (map[i]) begin
        res = PRIO_W'(i);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/priority_bitmap_task_scheduler_unit.sv
// one event at a time: a new input beat is taken only in the idle state
// a tick walks over the delay memory, one entry per cycle, through its single
// read port, read-modify-write with a registered read
// reset: synchronous active-low rst_n clears ready map, lock, delay valid bits,
// sets running priority to none and ms_per_tick to 1
`default_nettype none

module priority_bitmap_task_scheduler_unit
  import pbts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [MS_W-1:0]      cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [TASK_W-1:0]    in_target_prio,
  input  wire logic                 in_target_self,
  input  wire logic [DLY_W-1:0]     in_delay_amount,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PRIO_W-1:0]         out_running_prio,
  output logic                      out_switched,
  output logic [NUM_TASKS-1:0]      out_ready_bits
);

  state_t state_r, state_nxt;

  logic [MS_W-1:0]      ms_r;
  logic [NUM_TASKS-1:0] ready_r, ready_nxt;
  logic [PRIO_W-1:0]    cur_r, cur_nxt;
  logic                 locked_r, locked_nxt;
  logic                 resched_r, resched_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  logic [FUNC_W-1:0]    func_r;
  logic [TASK_W-1:0]    prio_r;
  logic                 self_r;
  logic [DLY_W-1:0]     amount_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [PRIO_W-1:0]    out_prio_r, out_prio_nxt;
  logic                 out_sw_r, out_sw_nxt;
  logic [NUM_TASKS-1:0] out_bits_r, out_bits_nxt;

  // delay memory
  logic [DLY_W-1:0]     dly_mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] dvalid_r;
  logic                 mem_we;
  logic [TASK_W-1:0]    mem_waddr;
  logic [DLY_W-1:0]     mem_wdata;
  logic [TASK_W-1:0]    rd_addr;
  logic [DLY_W-1:0]     rd_data_r;
  logic                 rd_live_r;

  logic                 in_fire;
  logic                 out_free;
  logic [IDX_W-1:0]     proc_idx;
  logic [TASK_W-1:0]    proc_task;
  logic [DLY_W-1:0]     cur_dly;
  logic [DLY_W-1:0]     ms_ext;
  logic [TASK_W-1:0]    sus_task;
  logic [PRIO_W-1:0]    best_prio;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign rd_addr   = idx_r[TASK_W-1:0];
  assign proc_idx  = idx_r - IDX_W'(1);
  assign proc_task = proc_idx[TASK_W-1:0];
  assign cur_dly   = rd_live_r ? rd_data_r : '0;
  assign ms_ext    = DLY_W'(ms_r);
  assign sus_task  = self_r ? cur_r[TASK_W-1:0] : prio_r;
  assign best_prio = pick_prio(ready_r);

  assign out_valid        = out_valid_r;
  assign out_running_prio = out_prio_r;
  assign out_switched     = out_sw_r;
  assign out_ready_bits   = out_bits_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_func == FUNC_TICK) ? S_TICK : S_EXEC;
        end
      end
      S_TICK: begin
        if (idx_r == IDX_W'(NUM_TASKS)) begin
          state_nxt = S_DONE;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath
  always_comb begin
    ready_nxt     = ready_r;
    cur_nxt       = cur_r;
    locked_nxt    = locked_r;
    resched_nxt   = resched_r;
    idx_nxt       = idx_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_prio_nxt  = out_prio_r;
    out_sw_nxt    = out_sw_r;
    out_bits_nxt  = out_bits_r;
    case (state_r)
      S_IDLE: begin
        idx_nxt     = '0;
        resched_nxt = (in_func == FUNC_TICK);
      end
      S_TICK: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r != '0 && cur_dly != '0 && ms_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = proc_task;
          if (cur_dly <= ms_ext) begin
            mem_wdata            = '0;
            ready_nxt[proc_task] = 1'b1;
          end else begin
            mem_wdata = cur_dly - ms_ext;
          end
        end
      end
      S_EXEC: begin
        case (func_r)
          FUNC_SUSPEND: begin
            if (!(self_r && cur_r == PRIO_NONE) && !(!self_r && prio_r == IDLE_TASK)) begin
              mem_we              = 1'b1;
              mem_waddr           = sus_task;
              ready_nxt[sus_task] = 1'b0;
              resched_nxt         = (cur_r == {1'b0, sus_task});
            end
          end
          FUNC_RESUME: begin
            mem_we            = 1'b1;
            mem_waddr         = prio_r;
            ready_nxt[prio_r] = 1'b1;
            resched_nxt       = (cur_r > {1'b0, prio_r});
          end
          FUNC_DELAY: begin
            if (amount_r != '0 && cur_r != PRIO_NONE) begin
              mem_we                        = 1'b1;
              mem_waddr                     = cur_r[TASK_W-1:0];
              mem_wdata                     = amount_r;
              ready_nxt[cur_r[TASK_W-1:0]] = 1'b0;
              resched_nxt                   = 1'b1;
            end
          end
          FUNC_LOCK: begin
            locked_nxt = 1'b1;
          end
          FUNC_UNLOCK: begin
            locked_nxt  = 1'b0;
            resched_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bits_nxt  = ready_r;
          if (resched_r && !locked_r) begin
            cur_nxt      = best_prio;
            out_prio_nxt = best_prio;
            out_sw_nxt   = (best_prio != cur_r);
          end else begin
            out_prio_nxt = cur_r;
            out_sw_nxt   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ms_r        <= MS_RESET;
      ready_r     <= '0;
      cur_r       <= PRIO_NONE;
      locked_r    <= 1'b0;
      resched_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      dvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      cur_r       <= cur_nxt;
      locked_r    <= locked_nxt;
      resched_r   <= resched_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        ms_r <= cfg_wdata;
      end
      if (mem_we) begin
        dvalid_r[mem_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= in_func;
      prio_r   <= in_target_prio;
      self_r   <= in_target_self;
      amount_r <= in_delay_amount;
    end
    out_prio_r <= out_prio_nxt;
    out_sw_r   <= out_sw_nxt;
    out_bits_r <= out_bits_nxt;
  end

  // delay memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dly_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= dly_mem[rd_addr];
    rd_live_r <= dvalid_r[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/pbts_chk.sv
`default_nettype none

module pbts_chk
  import pbts_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 cfg_we,
  input wire logic [MS_W-1:0]      cfg_wdata,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic [FUNC_W-1:0]    in_func,
  input wire logic [TASK_W-1:0]    in_target_prio,
  input wire logic                 in_target_self,
  input wire logic [DLY_W-1:0]     in_delay_amount,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [PRIO_W-1:0]    out_running_prio,
  input wire logic                 out_switched,
  input wire logic [NUM_TASKS-1:0] out_ready_bits
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_running_prio)
      && $stable(out_switched) && $stable(out_ready_bits))
    else $error("result beat changed while stalled");

  // one event in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second input beat taken while busy");

  a_prio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_running_prio <= PRIO_NONE)
    else $error("running priority out of range");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output not quiet after reset");

endmodule

bind priority_bitmap_task_scheduler_unit pbts_chk u_pbts_chk (.*);

`default_nettype wire

>>> tb/pbts_result_checker.sv
`timescale 1ns / 100ps

module pbts_result_checker
  import pbts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [MS_W-1:0]      cfg_wdata,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [TASK_W-1:0]    in_target_prio,
  input  wire logic                 in_target_self,
  input  wire logic [DLY_W-1:0]     in_delay_amount,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic [PRIO_W-1:0]    out_running_prio,
  input  wire logic                 out_switched,
  input  wire logic [NUM_TASKS-1:0] out_ready_bits,
  output int                        mismatches,
  output int                        pending
);

  typedef struct packed {
    logic [PRIO_W-1:0]    running_prio;
    logic                 switched;
    logic [NUM_TASKS-1:0] ready_bits;
  } sched_result_t;

  logic [NUM_TASKS-1:0] ready_map_m;
  logic [DLY_W-1:0]     delay_m [NUM_TASKS];
  logic [PRIO_W-1:0]    running_m;
  logic                 locked_m;
  logic [MS_W-1:0]      tick_ms_m;
  sched_result_t        results_due [$];
  sched_result_t        seen;
  sched_result_t        due;
  int                   errors;

  initial begin
    errors = 0;
    mismatches = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // lowest ready task runs; returns 1 when the running task changes
  function automatic logic pick_running();
    logic [PRIO_W-1:0] next;
    next = PRIO_NONE;
    if (locked_m) begin
      return 1'b0;
    end
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (ready_map_m[i] && next == PRIO_NONE) begin
        next = PRIO_W'(i);
      end
    end
    if (next == running_m) begin
      return 1'b0;
    end
    running_m = next;
    return 1'b1;
  endfunction

  function automatic sched_result_t apply_sched_event(input logic [FUNC_W-1:0] func,
                                                      input logic [TASK_W-1:0] prio,
                                                      input logic self_sel,
                                                      input logic [DLY_W-1:0] amount);
    logic [PRIO_W-1:0] target;
    logic              sw;
    sched_result_t     res;
    sw = 1'b0;
    target = PRIO_W'(prio);
    case (func)
      FUNC_TICK: begin
        if (tick_ms_m != '0) begin
          for (int i = 0; i < NUM_TASKS; i++) begin
            if (delay_m[i] != '0) begin
              if (delay_m[i] <= DLY_W'(tick_ms_m)) begin
                delay_m[i] = '0;
                ready_map_m[i] = 1'b1;
              end else begin
                delay_m[i] = delay_m[i] - DLY_W'(tick_ms_m);
              end
            end
          end
        end
        sw = pick_running();
      end
      FUNC_SUSPEND: begin
        if (self_sel) begin
          target = running_m;
        end
        // idle task by number is protected, self-suspend of idle is not
        if ((self_sel || prio != IDLE_TASK) && target < NUM_TASKS) begin
          delay_m[target[TASK_W-1:0]] = '0;
          ready_map_m[target[TASK_W-1:0]] = 1'b0;
          if (running_m == target) begin
            sw = pick_running();
          end
        end
      end
      FUNC_RESUME: begin
        delay_m[prio] = '0;
        ready_map_m[prio] = 1'b1;
        if (running_m > target) begin
          sw = pick_running();
        end
      end
      FUNC_DELAY: begin
        if (amount != '0 && running_m < NUM_TASKS) begin
          ready_map_m[running_m[TASK_W-1:0]] = 1'b0;
          delay_m[running_m[TASK_W-1:0]] = amount;
          sw = pick_running();
        end
      end
      FUNC_LOCK: begin
        locked_m = 1'b1;
      end
      FUNC_UNLOCK: begin
        locked_m = 1'b0;
        sw = pick_running();
      end
      default: begin
      end
    endcase
    res.running_prio = running_m;
    res.switched = sw;
    res.ready_bits = ready_map_m;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ready_map_m = '0;
      foreach (delay_m[i]) delay_m[i] = '0;
      running_m = PRIO_NONE;
      locked_m = 1'b0;
      tick_ms_m = MS_RESET;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        tick_ms_m = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        results_due.push_back(apply_sched_event(in_func, in_target_prio, in_target_self,
                                                in_delay_amount));
      end
      if (out_valid && out_ready) begin
        seen = '{out_running_prio, out_switched, out_ready_bits};
        if (results_due.size() == 0) begin
          report_mismatch("result beat with nothing due", 32'(seen), '0);
        end else begin
          due = results_due.pop_front();
          if (seen.running_prio !== due.running_prio) begin
            report_mismatch("running_prio", 32'(seen.running_prio), 32'(due.running_prio));
          end
          if (seen.switched !== due.switched) begin
            report_mismatch("switched", 32'(seen.switched), 32'(due.switched));
          end
          if (seen.ready_bits !== due.ready_bits) begin
            report_mismatch("ready_bits", 32'(seen.ready_bits), 32'(due.ready_bits));
          end
        end
      end
    end
    pending <= results_due.size();
    mismatches <= errors;
  end

endmodule

>>> tb/tb_priority_bitmap_task_scheduler_unit.sv
`timescale 1ns / 100ps

module tb_priority_bitmap_task_scheduler_unit;
  import pbts_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO  = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;
  localparam int                ITEMS_PER_SET  = 260;
  localparam int                NUM_SETS       = 6;
  localparam int unsigned       HOLD_CYCLES    = 400;
  localparam int unsigned       QUIET_LIMIT    = 4000;
  localparam int                SETTLE_CYCLES  = 16;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TASK_W-1:0] prio;
    logic              self_sel;
    logic [DLY_W-1:0]  amount;
  } sched_event_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [MS_W-1:0]      cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FUNC_W-1:0]    in_func = '0;
  logic [TASK_W-1:0]    in_target_prio = '0;
  logic                 in_target_self = 1'b0;
  logic [DLY_W-1:0]     in_delay_amount = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PRIO_W-1:0]    out_running_prio;
  logic                 out_switched;
  logic [NUM_TASKS-1:0] out_ready_bits;
  int                   mismatches;
  int                   pending;

  int unsigned          snd_idle_pct = 27;
  int unsigned          rcv_idle_pct = 62;
  logic                 hold_go = 1'b0;
  logic                 hold_done = 1'b0;
  int unsigned          hold_left = 0;
  logic [MS_W-1:0]      tick_ms = MS_RESET;

  always #4 clk = ~clk;

  priority_bitmap_task_scheduler_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_target_prio   (in_target_prio),
    .in_target_self   (in_target_self),
    .in_delay_amount  (in_delay_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_running_prio (out_running_prio),
    .out_switched     (out_switched),
    .out_ready_bits   (out_ready_bits)
  );

  pbts_result_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_target_prio   (in_target_prio),
    .in_target_self   (in_target_self),
    .in_delay_amount  (in_delay_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_running_prio (out_running_prio),
    .out_switched     (out_switched),
    .out_ready_bits   (out_ready_bits),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic send_event(input sched_event_t ev);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= ev.func;
    in_target_prio <= ev.prio;
    in_target_self <= ev.self_sel;
    in_delay_amount <= ev.amount;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_tick_ms(input logic [MS_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_ms = value;
  endtask

  function automatic sched_event_t random_event(input logic [MS_W-1:0] ms);
    sched_event_t ev;
    int unsigned  pick;
    int unsigned  span;
    ev.prio = TASK_W'($urandom_range(NUM_TASKS - 1));
    ev.self_sel = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 30) begin
      ev.func = FUNC_TICK;
    end else if (pick < 50) begin
      ev.func = FUNC_RESUME;
    end else if (pick < 64) begin
      ev.func = FUNC_SUSPEND;
    end else if (pick < 78) begin
      ev.func = FUNC_DELAY;
    end else if (pick < 84) begin
      ev.func = FUNC_LOCK;
    end else if (pick < 94) begin
      ev.func = FUNC_UNLOCK;
    end else begin
      ev.func = pick[0] ? FUNC_SPARE_HI : FUNC_SPARE_LO;
    end
    // mostly delays that expire within a few ticks
    span = (ms == '0) ? 40 : 6 * int'(ms);
    if (span > 65535) begin
      span = 65535;
    end
    pick = $urandom_range(99);
    if (pick < 8) begin
      ev.amount = '0;
    end else if (pick < 16) begin
      ev.amount = DLY_W'($urandom_range(65535));
    end else begin
      ev.amount = DLY_W'($urandom_range(span, 1));
    end
    return ev;
  endfunction

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    sched_event_t    ev;
    int              sent;
    logic [MS_W-1:0] ms_plan [NUM_SETS];
    ms_plan[0] = 10'd1000;
    ms_plan[1] = 10'd0;
    ms_plan[2] = 10'd1023;
    ms_plan[3] = 10'd3;
    ms_plan[4] = 10'd1;
    ms_plan[5] = MS_W'($urandom_range(999, 2));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_event('{FUNC_SPARE_LO, 3'd5, 1'b1, 16'hffff});
    send_event('{FUNC_SUSPEND, 3'd2, 1'b1, 16'd0});
    send_event('{FUNC_DELAY, 3'd0, 1'b0, 16'd5});
    send_event('{FUNC_TICK, 3'd7, 1'b1, 16'd0});
    send_event('{FUNC_RESUME, 3'd7, 1'b0, 16'd0});
    send_event('{FUNC_RESUME, 3'd0, 1'b0, 16'd0});
    send_event('{FUNC_RESUME, 3'd3, 1'b1, 16'hffff});
    send_event('{FUNC_SUSPEND, 3'd7, 1'b0, 16'd0});
    send_event('{FUNC_DELAY, 3'd6, 1'b0, 16'd0});
    send_event('{FUNC_DELAY, 3'd1, 1'b1, 16'd2});
    send_event('{FUNC_LOCK, 3'd4, 1'b0, 16'd7});
    send_event('{FUNC_SUSPEND, 3'd3, 1'b0, 16'd0});
    send_event('{FUNC_TICK, 3'd0, 1'b0, 16'd0});
    send_event('{FUNC_TICK, 3'd5, 1'b0, 16'h8000});
    send_event('{FUNC_LOCK, 3'd0, 1'b0, 16'd0});
    send_event('{FUNC_UNLOCK, 3'd6, 1'b1, 16'd0});
    send_event('{FUNC_SUSPEND, 3'd0, 1'b1, 16'd0});
    send_event('{FUNC_SUSPEND, 3'd4, 1'b1, 16'd0});
    send_event('{FUNC_RESUME, 3'd5, 1'b0, 16'd0});
    send_event('{FUNC_DELAY, 3'd2, 1'b0, 16'hffff});
    send_event('{FUNC_SPARE_HI, 3'd1, 1'b0, 16'h5555});
    send_event('{FUNC_RESUME, 3'd2, 1'b0, 16'haaaa});
    send_event('{FUNC_DELAY, 3'd3, 1'b0, 16'd1});
    send_event('{FUNC_TICK, 3'd1, 1'b1, 16'd0});

    for (int p = 0; p < NUM_SETS; p++) begin
      write_tick_ms(ms_plan[p]);
      if (p == 1) begin
        hold_go <= 1'b1;
      end
      if (p < 2) begin
        snd_idle_pct = 27;
        rcv_idle_pct <= 62;
      end else if (p < 4) begin
        snd_idle_pct = 62;
        rcv_idle_pct <= 27;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
      end
      sent = 0;
      while (sent < ITEMS_PER_SET) begin
        ev = random_event(tick_ms);
        send_event(ev);
        sent++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/pbts_pkg.sv
hdl/priority_bitmap_task_scheduler_unit.sv
hdl/pbts_chk.sv
tb/pbts_result_checker.sv
tb/tb_priority_bitmap_task_scheduler_unit.sv
